// ===== design/bdsl_pkg.sv =====
// Package for the button debounce and short/long press unit.
// Shared widths, register indexes, reset values and the per-button event struct.
// No dependencies.
`default_nettype none

package bdsl_pkg;

  localparam int NumButtonsDef = 4;
  localparam int FieldW        = 4;
  localparam int TimeW         = 32;
  localparam int CfgW          = 16;
  localparam int CfgAddrW      = 4;

  localparam int InDataW  = ((TimeW + FieldW + 7) / 8) * 8;
  localparam int OutDataW = ((5 * FieldW + 7) / 8) * 8;

  localparam logic [CfgAddrW-1:0] CfgDebounce  = CfgAddrW'(0);
  localparam logic [CfgAddrW-1:0] CfgLongPress = CfgAddrW'(1);

  localparam logic [CfgW-1:0] DebounceRst  = CfgW'(20);
  localparam logic [CfgW-1:0] LongPressRst = CfgW'(1000);

  typedef struct packed {
    logic lvl;
    logic prs;
    logic rel;
    logic shrt;
    logic lng;
  } btn_evt_t;

endpackage

`default_nettype wire

// ===== design/button_debounce_short_long_press_unit.sv =====
// Top level of the button debounce and short/long press unit.
// Depends on bdsl_pkg and bdsl_button.
//
// Usage:
//   Each request on the in_ channel is one poll: a 32-bit millisecond timestamp and
//   one raw pressed bit per button. Each poll gives exactly one result on the out_
//   channel: debounced levels and press, release, short-press and long-press flags.
//   Registers: index 0 debounce time, index 1 long-press time (ms, 16 bit), written
//   through cfg_wr_en/cfg_addr/cfg_wdata by the user while the unit is idle (not enforced).
// Timing:
//   A poll is captured in an input register, classified by per-button compare logic,
//   and its result lands in the output register, which drives out_tvalid. One poll
//   per cycle is sustained, back to back, while out_tready stays high.
// Reset:
//   rst_n (synchronous, active low) empties both registers, clears button state and
//   restores debounce 20 ms and long press 1000 ms. The first poll after reset only
//   takes up the raw levels and reports no events.
// Stall:
//   A stalled result is held in the output register; an empty input register still
//   takes one more poll, after which in_tready drops until out_tready returns.
`default_nettype none

module button_debounce_short_long_press_unit #(
  parameter int NUM_BUTTONS = bdsl_pkg::NumButtonsDef
) (
  input  wire                            clk,
  input  wire                            rst_n,
  // in_tdata: now_ms[31:0], raw_buttons[35:32], zero pad
  input  wire                            in_tvalid,
  output logic                           in_tready,
  input  wire [bdsl_pkg::InDataW-1:0]    in_tdata,
  // out_tdata: stable_levels[3:0], press_events[7:4], release_events[11:8],
  //            short_press_events[15:12], long_press_events[19:16], zero pad
  output logic                           out_tvalid,
  input  wire                            out_tready,
  output logic [bdsl_pkg::OutDataW-1:0]  out_tdata,
  input  wire                            cfg_wr_en,
  input  wire [bdsl_pkg::CfgAddrW-1:0]   cfg_addr,
  input  wire [bdsl_pkg::CfgW-1:0]       cfg_wdata
);

  localparam int FW = bdsl_pkg::FieldW;

  logic [bdsl_pkg::CfgW-1:0]  debounce_time_r;
  logic [bdsl_pkg::CfgW-1:0]  long_press_time_r;

  logic                       in_vld_r;
  logic [bdsl_pkg::TimeW-1:0] in_now_r;
  logic [FW-1:0]              in_raw_r;

  logic                       out_vld_r;
  logic [bdsl_pkg::OutDataW-1:0] out_data_r, out_data_nxt;

  logic                       adv;
  logic                       step;
  logic [NUM_BUTTONS-1:0]     raw_ext;
  bdsl_pkg::btn_evt_t         evt [NUM_BUTTONS];

  logic [FW-1:0] lv_nxt, pe_nxt, re_nxt, se_nxt, le_nxt;

  assign adv       = !out_vld_r || out_tready;
  assign step      = in_vld_r && adv;
  assign in_tready = !in_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_time_r   <= bdsl_pkg::DebounceRst;
      long_press_time_r <= bdsl_pkg::LongPressRst;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        bdsl_pkg::CfgDebounce:  debounce_time_r   <= cfg_wdata;
        bdsl_pkg::CfgLongPress: long_press_time_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_now_r <= in_tdata[bdsl_pkg::TimeW-1:0];
      in_raw_r <= in_tdata[bdsl_pkg::TimeW +: FW];
    end
  end

  genvar i;
  generate
    for (i = 0; i < NUM_BUTTONS; i++) begin : g_btn
      if (i < FW) begin : g_raw
        assign raw_ext[i] = in_raw_r[i];
        assign lv_nxt[i]  = evt[i].lvl;
        assign pe_nxt[i]  = evt[i].prs;
        assign re_nxt[i]  = evt[i].rel;
        assign se_nxt[i]  = evt[i].shrt;
        assign le_nxt[i]  = evt[i].lng;
      end else begin : g_zero
        assign raw_ext[i] = 1'b0;
      end

      bdsl_button u_btn (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (step),
        .now_ms          (in_now_r),
        .raw             (raw_ext[i]),
        .debounce_time   (debounce_time_r),
        .long_press_time (long_press_time_r),
        .evt             (evt[i])
      );
    end

    for (i = NUM_BUTTONS; i < FW; i++) begin : g_unused
      assign lv_nxt[i] = 1'b0;
      assign pe_nxt[i] = 1'b0;
      assign re_nxt[i] = 1'b0;
      assign se_nxt[i] = 1'b0;
      assign le_nxt[i] = 1'b0;
    end
  endgenerate

  assign out_data_nxt = {{(bdsl_pkg::OutDataW - 5*FW){1'b0}},
                         le_nxt, se_nxt, re_nxt, pe_nxt, lv_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

// ===== design/bdsl_button.sv =====
// Per-button debounce and press classifier: holds one button's state.
// Depends on bdsl_pkg.
`default_nettype none

module bdsl_button (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         step,
  input  wire [bdsl_pkg::TimeW-1:0]   now_ms,
  input  wire                         raw,
  input  wire [bdsl_pkg::CfgW-1:0]    debounce_time,
  input  wire [bdsl_pkg::CfgW-1:0]    long_press_time,
  output bdsl_pkg::btn_evt_t          evt
);

  logic                       seen_r;
  logic                       lvl_r, lvl_nxt;
  logic                       prev_r, prev_nxt;
  logic [bdsl_pkg::TimeW-1:0] lct_r, lct_nxt;
  logic [bdsl_pkg::TimeW-1:0] pst_r, pst_nxt;
  logic                       lr_r, lr_nxt;

  logic                       chg;
  logic                       db_ok;
  logic                       take;
  logic                       lr_eff;
  logic                       lp;
  logic [bdsl_pkg::TimeW-1:0] db_diff;
  logic [bdsl_pkg::TimeW-1:0] lp_diff;

  always_comb begin
    chg      = (raw != prev_r);
    lct_nxt  = (chg || !seen_r) ? now_ms : lct_r;
    db_diff  = now_ms - lct_nxt;
    db_ok    = (db_diff >= {{(bdsl_pkg::TimeW-bdsl_pkg::CfgW){1'b0}}, debounce_time});
    take     = seen_r && db_ok && (lvl_r != raw);
    prev_nxt = raw;
    if (!seen_r) begin
      lvl_nxt = raw;
    end else begin
      lvl_nxt = take ? raw : lvl_r;
    end
    pst_nxt  = (take && raw) ? now_ms : pst_r;
    lr_eff   = (take && raw) ? 1'b0 : lr_r;
    lp_diff  = now_ms - pst_nxt;
    lp       = seen_r && lvl_nxt && !lr_eff &&
               (lp_diff >= {{(bdsl_pkg::TimeW-bdsl_pkg::CfgW){1'b0}}, long_press_time});
    lr_nxt   = seen_r ? (lr_eff | lp) : lr_r;

    evt.lvl  = lvl_nxt;
    evt.prs  = take && raw;
    evt.rel  = take && !raw;
    evt.shrt = take && !raw && !lr_r;
    evt.lng  = lp;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 1'b0;
      lvl_r  <= 1'b0;
      prev_r <= 1'b0;
      lct_r  <= '0;
      pst_r  <= '0;
      lr_r   <= 1'b0;
    end else if (step) begin
      seen_r <= 1'b1;
      lvl_r  <= lvl_nxt;
      prev_r <= prev_nxt;
      lct_r  <= lct_nxt;
      pst_r  <= pst_nxt;
      lr_r   <= lr_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== test/button_debounce_short_long_press_unit_tb.sv =====
// Testbench for button_debounce_short_long_press_unit: directed and random button polls.
// An in-bench model of the debounce/press logic predicts each result, which is checked.
// Depends on bdsl_pkg and the unit's RTL.
`default_nettype none

module button_debounce_short_long_press_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumBtn = 4;
  localparam logic [bdsl_pkg::CfgAddrW-1:0] CfgNoReg    = bdsl_pkg::CfgAddrW'(14);
  localparam logic [bdsl_pkg::CfgAddrW-1:0] CfgPastLast = bdsl_pkg::CfgAddrW'(2);

  typedef struct packed {
    logic [3:0] long_ev;
    logic [3:0] short_ev;
    logic [3:0] rel_ev;
    logic [3:0] press_ev;
    logic [3:0] levels;
  } poll_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [bdsl_pkg::InDataW-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready;
  logic [bdsl_pkg::OutDataW-1:0] out_tdata;
  logic cfg_wr_en = 1'b0;
  logic [bdsl_pkg::CfgAddrW-1:0] cfg_addr = '0;
  logic [bdsl_pkg::CfgW-1:0] cfg_wdata = '0;

  // button model state
  logic [bdsl_pkg::CfgW-1:0] debounce_ms;
  logic [bdsl_pkg::CfgW-1:0] long_ms;
  logic [NumBtn-1:0] btn_seen;
  logic [NumBtn-1:0] btn_level;
  logic [NumBtn-1:0] btn_prev_raw;
  logic [NumBtn-1:0] btn_long_done;
  logic [bdsl_pkg::TimeW-1:0] btn_change_ms [NumBtn];
  logic [bdsl_pkg::TimeW-1:0] btn_press_ms [NumBtn];

  poll_result_t pending_results[$];
  int fail_count = 0;
  int hold_cycles = 0;
  bit idle_on = 1'b1;
  logic [bdsl_pkg::TimeW-1:0] cur_ms = '0;

  button_debounce_short_long_press_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic void reset_buttons();
    debounce_ms = bdsl_pkg::DebounceRst;
    long_ms = bdsl_pkg::LongPressRst;
    btn_seen = '0;
    btn_level = '0;
    btn_prev_raw = '0;
    btn_long_done = '0;
    for (int b = 0; b < NumBtn; b++) begin
      btn_change_ms[b] = '0;
      btn_press_ms[b] = '0;
    end
  endfunction

  function automatic poll_result_t classify_poll(logic [bdsl_pkg::TimeW-1:0] now,
                                                 logic [3:0] raw);
    poll_result_t r;
    r = '0;
    for (int b = 0; b < NumBtn; b++) begin
      if (!btn_seen[b]) begin
        btn_seen[b] = 1'b1;
        btn_level[b] = raw[b];
        btn_prev_raw[b] = raw[b];
        btn_change_ms[b] = now;
      end else begin
        if (raw[b] != btn_prev_raw[b]) begin
          btn_prev_raw[b] = raw[b];
          btn_change_ms[b] = now;
        end
        if (bdsl_pkg::TimeW'(now - btn_change_ms[b]) >= bdsl_pkg::TimeW'(debounce_ms) &&
            btn_level[b] != raw[b]) begin
          btn_level[b] = raw[b];
          if (raw[b]) begin
            r.press_ev[b] = 1'b1;
            btn_press_ms[b] = now;
            btn_long_done[b] = 1'b0;
          end else begin
            r.rel_ev[b] = 1'b1;
            if (!btn_long_done[b]) r.short_ev[b] = 1'b1;
          end
        end
        if (btn_level[b] && !btn_long_done[b] &&
            bdsl_pkg::TimeW'(now - btn_press_ms[b]) >= bdsl_pkg::TimeW'(long_ms)) begin
          btn_long_done[b] = 1'b1;
          r.long_ev[b] = 1'b1;
        end
      end
      r.levels[b] = btn_level[b];
    end
    return r;
  endfunction

  function automatic void check_field(string name, logic [3:0] exp, logic [3:0] act);
    if (exp !== act) begin
      $error("%s: expected %h, got %h", name, exp, act);
      fail_count++;
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    poll_result_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: %h", out_tdata);
        fail_count++;
      end else begin
        e = pending_results.pop_front();
        check_field("stable_levels", e.levels, out_tdata[3:0]);
        check_field("press_events", e.press_ev, out_tdata[7:4]);
        check_field("release_events", e.rel_ev, out_tdata[11:8]);
        check_field("short_press_events", e.short_ev, out_tdata[15:12]);
        check_field("long_press_events", e.long_ev, out_tdata[19:16]);
      end
    end
  end

  // result receiver with random stalls and long holds
  initial begin
    int gap_left;
    gap_left = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_tready <= 1'b0;
        hold_cycles--;
      end else if (gap_left > 0) begin
        out_tready <= 1'b0;
        gap_left--;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        out_tready <= 1'b0;
        gap_left = $urandom_range(0, 14);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send_poll(input logic [bdsl_pkg::TimeW-1:0] now, input logic [3:0] raw);
    int gap;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 15);
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= bdsl_pkg::InDataW'({raw, now});
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(classify_poll(now, raw));
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [bdsl_pkg::CfgAddrW-1:0] addr,
                           input logic [bdsl_pkg::CfgW-1:0] value);
    drain();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    if (addr == bdsl_pkg::CfgDebounce) debounce_ms = value;
    else if (addr == bdsl_pkg::CfgLongPress) long_ms = value;
  endtask

  // buttons held on the first poll time their press from zero
  task automatic test_first_poll_held();
    send_poll(32'd5, 4'b1010);
    send_poll(32'd500, 4'b1010);
    send_poll(32'd1000, 4'b1010);
    send_poll(32'd1100, 4'b1000);
    send_poll(32'd1120, 4'b1000);
    send_poll(32'd1200, 4'b0001);
    send_poll(32'd1230, 4'b0000);
    send_poll(32'd1260, 4'b0000);
  endtask

  task automatic test_time_wrap();
    send_poll(32'hFFFF_FFF0, 4'b0100);
    send_poll(32'h0000_0004, 4'b0100);
    send_poll(32'h0000_0010, 4'b1111);
    send_poll(32'h0000_0030, 4'b1111);
    send_poll(32'h0000_03F0, 4'b1111);
    send_poll(32'h0000_0500, 4'b0000);
    send_poll(32'h0000_0520, 4'b0000);
  endtask

  task automatic test_zero_times();
    write_reg(bdsl_pkg::CfgDebounce, '0);
    write_reg(bdsl_pkg::CfgLongPress, '0);
    send_poll(32'h8000_0000, 4'b1111);
    send_poll(32'h8000_0000, 4'b0000);
    send_poll(32'h8000_0001, 4'b0101);
    write_reg(bdsl_pkg::CfgDebounce, '1);
    write_reg(bdsl_pkg::CfgLongPress, '1);
    send_poll(32'h8000_0002, 4'b1010);
    send_poll(32'h8001_0001, 4'b1010);
    send_poll(32'h8002_0001, 4'b1010);
  endtask

  // writes to an unmapped index must leave both registers alone
  task automatic test_unused_register();
    write_reg(CfgNoReg, '1);
    write_reg(CfgPastLast, '0);
    send_poll(32'h8002_0002, 4'b0000);
    send_poll(32'h8003_0002, 4'b0000);
  endtask

  task automatic test_backpressure();
    write_reg(bdsl_pkg::CfgDebounce, bdsl_pkg::CfgW'(2));
    write_reg(bdsl_pkg::CfgLongPress, bdsl_pkg::CfgW'(10));
    hold_cycles = 300;
    for (int k = 0; k < 40; k++) begin
      cur_ms += $urandom_range(0, 4);
      send_poll(cur_ms, 4'($urandom));
    end
  endtask

  task automatic run_random_phase(input int count, input int max_step, input int jump_odds);
    logic [3:0] intent;
    logic [3:0] raw;
    intent = 4'($urandom);
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, jump_odds) == 0) cur_ms = $urandom;
      else cur_ms += $urandom_range(0, max_step);
      for (int b = 0; b < NumBtn; b++)
        if ($urandom_range(0, 24) == 0) intent[b] = ~intent[b];
      raw = intent;
      if ($urandom_range(0, 9) == 0) raw ^= 4'($urandom);
      send_poll(cur_ms, raw);
    end
  endtask

  task automatic test_random_settings();
    logic [bdsl_pkg::CfgW-1:0] db;
    write_reg(bdsl_pkg::CfgDebounce, '0);
    write_reg(bdsl_pkg::CfgLongPress, '0);
    run_random_phase(150, 10, 80);
    write_reg(bdsl_pkg::CfgDebounce, '1);
    write_reg(bdsl_pkg::CfgLongPress, '1);
    run_random_phase(150, 30000, 80);
    for (int p = 0; p < 3; p++) begin
      db = bdsl_pkg::CfgW'($urandom_range(1, 40));
      write_reg(bdsl_pkg::CfgDebounce, db);
      write_reg(bdsl_pkg::CfgLongPress, bdsl_pkg::CfgW'($urandom_range(db, 300)));
      run_random_phase(250, 15, 100);
    end
    write_reg(bdsl_pkg::CfgDebounce, bdsl_pkg::CfgW'(5));
    write_reg(bdsl_pkg::CfgLongPress, bdsl_pkg::CfgW'(60));
    idle_on = 1'b0;
    run_random_phase(200, 8, 100);
  endtask

  initial begin
    #5_000_000;
    $display("button_debounce_short_long_press_unit test failed");
    $finish;
  end

  initial begin
    reset_buttons();
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    test_first_poll_held();
    test_time_wrap();
    test_zero_times();
    test_unused_register();
    test_backpressure();
    test_random_settings();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("button_debounce_short_long_press_unit test passed");
    end else begin
      $display("button_debounce_short_long_press_unit test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
